>>> hdl/kete_pkg.sv
// ----------------------------------------------------------------------------
// kete_pkg: shared definitions for the keyed entry table
// Table size, field widths, result status codes and the command and token
// structures that travel between the controller and the row of cells.
// ----------------------------------------------------------------------------
package kete_pkg;

	// Number of slots in the table.
	localparam int ENTRIES = 64;

	// Field widths of the transaction payload.
	localparam int KEY_W    = 16;
	localparam int VAR_W    = 8;
	localparam int SLOT_W   = 6;
	localparam int STATUS_W = 3;

	// Width of a slot position inside the row.
	localparam int POS_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Width used to compare a position against the requested read slot.
	localparam int CMP_W = (POS_W > SLOT_W) ? POS_W : SLOT_W;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_NEW        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPLACED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_KEPT       = 3'd2;
	localparam logic [STATUS_W-1:0] ST_KEY_ZERO   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVER_LIMIT = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;
	localparam logic [STATUS_W-1:0] ST_READ       = 3'd6;

	// Operation held by the controller and broadcast to every cell.
	typedef struct packed {
		logic              op_read;
		logic [KEY_W-1:0]  key;
		logic [VAR_W-1:0]  variant;
		logic              flag;
		logic [SLOT_W-1:0] target;
	} cmd_t;

	// Scan token that moves one cell to the right every cycle.
	typedef struct packed {
		logic                live;
		logic                done;
		logic [POS_W-1:0]    pos;
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    slot;
		logic [KEY_W-1:0]    rkey;
		logic [VAR_W-1:0]    rvariant;
		logic                rflag;
		logic                rvalid;
	} tok_t;

endpackage

>>> hdl/kete_cell.sv
// ----------------------------------------------------------------------------
// kete_cell: one slot of the keyed entry table
// Holds one entry and inspects the scan token as it passes. The first free
// or matching slot claims an insert, the addressed slot answers a read.
// ----------------------------------------------------------------------------
module kete_cell import kete_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  tok_t tok_in,
	output tok_t tok_out
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [VAR_W-1:0] variant_q;
	logic             flag_q;
	tok_t             tok_q;

	tok_t tok_nxt;
	logic here;
	logic wr_all;
	logic wr_flag;

	// Decide what this slot does with the token and build the outgoing token.
	always_comb begin
		tok_nxt     = tok_in;
		tok_nxt.pos = tok_in.pos + POS_W'(1);
		wr_all      = 1'b0;
		wr_flag     = 1'b0;
		here        = tok_in.live && !tok_in.done;
		if (here && !cmd.op_read) begin
			if (!valid_q) begin
				wr_all         = 1'b1;
				tok_nxt.done   = 1'b1;
				tok_nxt.status = ST_NEW;
				tok_nxt.slot   = tok_in.pos;
			end else if (key_q == cmd.key && variant_q == cmd.variant) begin
				tok_nxt.done   = 1'b1;
				tok_nxt.slot   = tok_in.pos;
				tok_nxt.status = cmd.flag ? ST_KEPT : ST_REPLACED;
				wr_flag        = !cmd.flag;
			end
		end else if (here && cmd.op_read &&
				CMP_W'(tok_in.pos) == CMP_W'(cmd.target)) begin
			tok_nxt.done   = 1'b1;
			tok_nxt.status = ST_READ;
			if (valid_q) begin
				tok_nxt.rkey     = key_q;
				tok_nxt.rvariant = variant_q;
				tok_nxt.rflag    = flag_q;
				tok_nxt.rvalid   = 1'b1;
			end
		end
	end

	// Valid bit and token register are control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (wr_all) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Entry contents only matter once the slot is valid.
	always_ff @(posedge clk) begin
		if (wr_all) begin
			key_q     <= cmd.key;
			variant_q <= cmd.variant;
		end
		if (wr_all || wr_flag) begin
			flag_q <= cmd.flag;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> hdl/kete_row.sv
// ----------------------------------------------------------------------------
// kete_row: the chain of table cells
// Links ENTRIES cells so that the scan token walks from slot 0 upward, one
// slot per clock, and leaves at the far end carrying the outcome.
// ----------------------------------------------------------------------------
module kete_row import kete_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  tok_t tok_in,
	output tok_t tok_out
);

	tok_t                chain [0:ENTRIES];
	logic [ENTRIES-1:0]  live_vec;

	assign chain[0] = tok_in;

	// One cell per slot, each handing its token to the next.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kete_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
		assign live_vec[i] = chain[i+1].live;
	end

	assign tok_out = chain[ENTRIES];

`ifndef SYNTH
	// Only one transaction is ever in flight along the row.
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(live_vec))
		else $error("more than one scan token in the row");
`endif

endmodule

>>> hdl/keyed_entry_table_insert.sv
// ----------------------------------------------------------------------------
// keyed_entry_table_insert: packed keyed entry table with insert and read
// Top level: input and output handshakes, operation control and result
// registers around the row of table cells.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. An insert with a zero key or a
// variant above its limit is answered straight from the controller without a
// scan and touches nothing. Every other insert, and every read, sends a token
// through the row of ENTRIES cells at one cell per clock, and the result is
// taken from the token that leaves the far end, whatever slot ends the scan.
// A new transaction is accepted once the previous result has moved into the
// output register, even while that result is still stalled.
// Reset clears the slot valid bits, token registers and control state, not entry contents.
module keyed_entry_table_insert import kete_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	input  logic [KEY_W-1:0]    entry_key,
	input  logic [VAR_W-1:0]    variant,
	input  logic                new_flag,
	input  logic [VAR_W-1:0]    variant_limit,
	input  logic [SLOT_W-1:0]   slot_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot_used,
	output logic [KEY_W-1:0]    read_key,
	output logic [VAR_W-1:0]    read_variant,
	output logic                read_flag,
	output logic                read_valid
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} ctl_state_t;

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	cmd_t cmd_q;
	logic launch_q;
	tok_t tok_launch;
	tok_t tok_exit;

	logic                accept;
	logic                needs_scan;
	logic                out_free;

	logic [STATUS_W-1:0] res_status_q;
	logic [POS_W-1:0]    res_slot_q;
	logic [KEY_W-1:0]    res_key_q;
	logic [VAR_W-1:0]    res_variant_q;
	logic                res_flag_q;
	logic                res_valid_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [VAR_W-1:0]    out_variant_q;
	logic                out_flag_q;
	logic                out_rvalid_q;

	// Input handshake and the choice between a scan and an immediate answer.
	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign needs_scan = func || (entry_key != '0 && variant <= variant_limit);
	assign out_free   = !out_valid_q || !out_stall;

	// Controller sequencing.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = needs_scan ? S_SCAN : S_FIN;
				end
			end
			S_SCAN: begin
				if (tok_exit.live) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			launch_q <= accept && needs_scan;
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the transaction and collect its result.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op_read <= func;
			cmd_q.key     <= entry_key;
			cmd_q.variant <= variant;
			cmd_q.flag    <= new_flag;
			cmd_q.target  <= slot_index;
			res_slot_q    <= '0;
			res_key_q     <= '0;
			res_variant_q <= '0;
			res_flag_q    <= 1'b0;
			res_valid_q   <= 1'b0;
			res_status_q  <= (entry_key == '0) ? ST_KEY_ZERO : ST_OVER_LIMIT;
		end else if (state_q == S_SCAN && tok_exit.live) begin
			res_slot_q    <= tok_exit.slot;
			res_key_q     <= tok_exit.rkey;
			res_variant_q <= tok_exit.rvariant;
			res_flag_q    <= tok_exit.rflag;
			res_valid_q   <= tok_exit.rvalid;
			if (tok_exit.done) begin
				res_status_q <= tok_exit.status;
			end else begin
				res_status_q <= cmd_q.op_read ? ST_READ : ST_FULL;
			end
		end
		if (state_q == S_FIN && out_free) begin
			out_status_q  <= res_status_q;
			out_slot_q    <= SLOT_W'(res_slot_q);
			out_key_q     <= res_key_q;
			out_variant_q <= res_variant_q;
			out_flag_q    <= res_flag_q;
			out_rvalid_q  <= res_valid_q;
		end
	end

	// Fresh token entering slot 0.
	always_comb begin
		tok_launch      = '0;
		tok_launch.live = launch_q;
	end

	kete_row u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_q),
		.tok_in  (tok_launch),
		.tok_out (tok_exit)
	);

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign slot_used    = out_slot_q;
	assign read_key     = out_key_q;
	assign read_variant = out_variant_q;
	assign read_flag    = out_flag_q;
	assign read_valid   = out_rvalid_q;

`ifndef SYNTH
	// A token only leaves the row while the controller waits for it.
	a_exit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_exit.live |-> state_q == S_SCAN)
		else $error("scan token left the row outside a scan");

	// A token is launched only right after a transaction that needs a scan.
	a_launch_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> state_q == S_SCAN && $past(accept))
		else $error("scan launched without an accepted transaction");

	// Read results never report a slot number.
	a_read_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_READ |-> slot_used == '0)
		else $error("read result carries a slot number");

	// Insert results never carry read data.
	a_insert_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_READ |-> !read_valid && read_key == '0)
		else $error("insert result carries read data");
`endif

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking regression for keyed_entry_table_insert
// Sends inserts and reads through the valid/stall handshake and keeps a
// shadow copy of the slot table to predict each result. Every returned
// transaction is compared field by field with the oldest prediction, under
// three idling mixes, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module testbench import kete_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Operation codes on the func input.
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	localparam int RANDOM_PER_PHASE = 500;
	localparam int KEY_POOL_SIZE    = 24;
	localparam int DRAIN_CYCLES     = ENTRIES + 10;
	localparam int LONG_HOLD        = 400;
	localparam int WATCHDOG_LIMIT   = 4000;

	// One request as offered to the block.
	typedef struct packed {
		logic              func;
		logic [KEY_W-1:0]  key;
		logic [VAR_W-1:0]  variant;
		logic              flag;
		logic [VAR_W-1:0]  limit;
		logic [SLOT_W-1:0] slot;
	} table_req_t;

	// One result as returned by the block.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_used;
		logic [KEY_W-1:0]    read_key;
		logic [VAR_W-1:0]    read_variant;
		logic                read_flag;
		logic                read_valid;
	} table_result_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_stall;
	logic                func          = FUNC_INSERT;
	logic [KEY_W-1:0]    entry_key     = '0;
	logic [VAR_W-1:0]    variant       = '0;
	logic                new_flag      = 1'b0;
	logic [VAR_W-1:0]    variant_limit = '0;
	logic [SLOT_W-1:0]   slot_index    = '0;
	logic                out_valid;
	logic                out_stall     = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_used;
	logic [KEY_W-1:0]    read_key;
	logic [VAR_W-1:0]    read_variant;
	logic                read_flag;
	logic                read_valid;

	// Shadow copy of the slot table.
	bit               shadow_valid   [ENTRIES];
	logic [KEY_W-1:0] shadow_key     [ENTRIES];
	logic [VAR_W-1:0] shadow_variant [ENTRIES];
	logic             shadow_flag    [ENTRIES];

	table_req_t    pending_reqs[$];
	table_result_t expected_results[$];
	table_req_t    offered_req = '0;
	table_req_t    next_req;
	table_result_t got_result;
	table_result_t want_result;

	int unsigned send_idle_pct    = 0;
	int unsigned recv_idle_pct    = 0;
	int unsigned long_hold_cycles = 0;
	int unsigned hold_count       = 0;
	int unsigned quiet_cycles     = 0;
	int unsigned fail_count       = 0;
	logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

	keyed_entry_table_insert i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.entry_key     (entry_key),
		.variant       (variant),
		.new_flag      (new_flag),
		.variant_limit (variant_limit),
		.slot_index    (slot_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.slot_used     (slot_used),
		.read_key      (read_key),
		.read_variant  (read_variant),
		.read_flag     (read_flag),
		.read_valid    (read_valid)
	);

	// Applies one accepted request to the shadow table and returns its result.
	function automatic table_result_t table_apply(table_req_t r);
		table_result_t res;
		res = '0;
		if (r.func == FUNC_READ) begin
			res.status = ST_READ;
			if (int'(r.slot) < ENTRIES && shadow_valid[r.slot]) begin
				res.read_key     = shadow_key[r.slot];
				res.read_variant = shadow_variant[r.slot];
				res.read_flag    = shadow_flag[r.slot];
				res.read_valid   = 1'b1;
			end
			return res;
		end
		if (r.key == '0) begin
			res.status = ST_KEY_ZERO;
			return res;
		end
		if (r.variant > r.limit) begin
			res.status = ST_OVER_LIMIT;
			return res;
		end
		// Scan upward to the first free slot or the first entry with the same
		// key and variant.
		for (int i = 0; i < ENTRIES; i++) begin
			if (!shadow_valid[i]) begin
				shadow_valid[i]   = 1'b1;
				shadow_key[i]     = r.key;
				shadow_variant[i] = r.variant;
				shadow_flag[i]    = r.flag;
				res.status        = ST_NEW;
				res.slot_used     = SLOT_W'(i);
				return res;
			end
			if (shadow_key[i] == r.key && shadow_variant[i] == r.variant) begin
				res.slot_used = SLOT_W'(i);
				if (r.flag) begin
					res.status = ST_KEPT;
				end else begin
					shadow_flag[i] = r.flag;
					res.status     = ST_REPLACED;
				end
				return res;
			end
		end
		res.status = ST_FULL;
		return res;
	endfunction

	// Reports one field; returns 1 when it matches.
	function automatic bit field_ok(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic table_req_t make_req(logic f, logic [KEY_W-1:0] k,
			logic [VAR_W-1:0] v, logic fl, logic [VAR_W-1:0] lim,
			logic [SLOT_W-1:0] s);
		table_req_t r;
		r.func    = f;
		r.key     = k;
		r.variant = v;
		r.flag    = fl;
		r.limit   = lim;
		r.slot    = s;
		return r;
	endfunction

	// Random request: mostly inserts, many on a small key pool so that matches
	// and replacements are common, with reads, ignored inserts and fresh keys mixed in.
	function automatic table_req_t random_req();
		table_req_t  r;
		int unsigned pick;
		r.func    = FUNC_INSERT;
		r.key     = KEY_W'($urandom_range(1, 65535));
		r.variant = VAR_W'($urandom_range(0, 255));
		r.flag    = 1'($urandom_range(0, 1));
		r.limit   = VAR_W'($urandom_range(0, 255));
		r.slot    = SLOT_W'($urandom_range(0, 63));
		pick      = $urandom_range(0, 99);
		if (pick < 30) begin
			r.func = FUNC_READ;
		end else if (pick < 38) begin
			r.key = '0;
		end else if (pick < 46) begin
			r.limit   = VAR_W'($urandom_range(0, 254));
			r.variant = VAR_W'($urandom_range(int'(r.limit) + 1, 255));
		end else if (pick < 58) begin
			r.limit = VAR_W'($urandom_range(int'(r.variant), 255));
		end else begin
			r.key     = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
			r.variant = VAR_W'($urandom_range(0, 3));
			r.limit   = VAR_W'($urandom_range(int'(r.variant), 255));
		end
		return r;
	endfunction

	// Waits until every queued transaction has been sent and answered.
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic push_random(int unsigned count);
		repeat (count) pending_reqs.push_back(random_req());
	endtask

	// Clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Input driver: offers queued requests and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(table_apply(offered_req));
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = pending_reqs.pop_front();
					in_valid      <= 1'b1;
					offered_req   <= next_req;
					func          <= next_req.func;
					entry_key     <= next_req.key;
					variant       <= next_req.variant;
					new_flag      <= next_req.flag;
					variant_limit <= next_req.limit;
					slot_index    <= next_req.slot;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each returned transaction and drives the stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got_result = '{status, slot_used, read_key, read_variant, read_flag,
					read_valid};
				if (expected_results.size() == 0) begin
					$error("result transaction with no prediction waiting");
					fail_count++;
				end else begin
					want_result = expected_results.pop_front();
					if (!(field_ok("status", want_result.status, got_result.status) &
							field_ok("slot_used", want_result.slot_used, got_result.slot_used) &
							field_ok("read_key", want_result.read_key, got_result.read_key) &
							field_ok("read_variant", want_result.read_variant,
								got_result.read_variant) &
							field_ok("read_flag", want_result.read_flag, got_result.read_flag) &
							field_ok("read_valid", want_result.read_valid,
								got_result.read_valid)))
						fail_count++;
				end
			end
			if (hold_count < long_hold_cycles) begin
				out_stall  <= 1'b1;
				hold_count <= hold_count + 1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when nothing is accepted for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("keyed_entry_table_insert regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus sequence.
	initial begin
		key_pool[0] = 16'hFFFF;
		key_pool[1] = 16'h0001;
		for (int i = 2; i < KEY_POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom_range(1, 65535));

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: empty reads, ignored inserts, new, kept and replaced.
		send_idle_pct = 7;
		recv_idle_pct = 48;
		pending_reqs.push_back(make_req(FUNC_READ, 16'h0000, 8'h00, 1'b0, 8'h00, 6'd0));
		pending_reqs.push_back(make_req(FUNC_READ, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 6'd63));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'h0000, 8'h00, 1'b0, 8'hFF, 6'd0));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'h0000, 8'hFF, 1'b1, 8'h00, 6'd63));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'hFFFF, 8'hFF, 1'b1, 8'hFE, 6'd0));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'h0001, 8'h01, 1'b0, 8'h00, 6'd0));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 6'd0));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'h0001, 8'h00, 1'b0, 8'h00, 6'd63));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 6'd0));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'hFFFF, 8'hFF, 1'b0, 8'hFF, 6'd0));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'h0001, 8'h00, 1'b1, 8'h00, 6'd0));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'h0001, 8'h00, 1'b0, 8'h05, 6'd0));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'h8000, 8'h80, 1'b1, 8'h80, 6'd0));
		pending_reqs.push_back(make_req(FUNC_INSERT, 16'h7FFF, 8'h7F, 1'b0, 8'hFF, 6'd0));
		pending_reqs.push_back(make_req(FUNC_READ, 16'h0000, 8'h00, 1'b0, 8'h00, 6'd0));
		pending_reqs.push_back(make_req(FUNC_READ, 16'h0000, 8'h00, 1'b0, 8'h00, 6'd1));
		pending_reqs.push_back(make_req(FUNC_READ, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 6'd2));
		pending_reqs.push_back(make_req(FUNC_READ, 16'h0000, 8'h00, 1'b0, 8'h00, 6'd3));
		pending_reqs.push_back(make_req(FUNC_READ, 16'h0000, 8'h00, 1'b0, 8'h00, 6'd63));
		pending_reqs.push_back(make_req(FUNC_READ, 16'h0000, 8'h00, 1'b0, 8'h00, 6'd42));

		// The sender pauses here until every prediction has been answered.
		wait_drained();

		// Random part, first mix: light sender idling, heavy receiver stalls.
		push_random(RANDOM_PER_PHASE);
		wait_drained();

		// Second mix: the other way round.
		send_idle_pct = 48;
		recv_idle_pct = 7;
		push_random(RANDOM_PER_PHASE);
		wait_drained();

		// Third mix: no idling, opened by a long receiver hold-off that backs
		// the block up into its input.
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		long_hold_cycles = LONG_HOLD;
		push_random(RANDOM_PER_PHASE);
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("keyed_entry_table_insert regression: pass");
		end else begin
			$display("keyed_entry_table_insert regression: fail");
		end
		$finish;
	end

endmodule
